### rtl/core/wrhp_pkg.sv
package wrhp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RIFF,
    PH_FMT_HDR,
    PH_FMT_SKIP,
    PH_FMT_BODY,
    PH_DATA_HDR,
    PH_DATA_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_RIFF  = 3'd1,
    ST_NO_FMT    = 3'd2,
    ST_NO_DATA   = 3'd3,
    ST_FMT_SHORT = 3'd4
  } status_t;

  localparam logic [31:0] TAG_RIFF    = 32'h4646_4952;
  localparam logic [31:0] TAG_FMT     = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA    = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN     = 32'd16;
  localparam logic [7:0]  TRIES_RESET = 8'd10;

  localparam logic [3:0] IDX_TAG_LAST  = 4'd3;
  localparam logic [3:0] IDX_SIZE_LAST = 4'd7;
  localparam logic [3:0] IDX_FORM_LAST = 4'd11;
  localparam logic [3:0] IDX_BODY_LAST = 4'd15;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] riff_size;
    logic [31:0] riff_form;
    logic [31:0] fmt_size;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
  } result_t;

endpackage

### rtl/core/wav_riff_header_parser.sv
// WAV RIFF header parser. Feed the file one byte per transaction with in_file_start set on
// the first byte; one result (header fields or an error status, all other fields zero on
// error) comes out per complete file, nothing for a truncated one. A byte is taken every
// cycle while the output queue has room: each byte updates the parse registers, and any
// result lands in that two-entry queue, so in_ready drops only while it holds two results.
// Configuration writes on cfg_ are always taken and must happen while the block is idle.
module wav_riff_header_parser
  import wrhp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_max_chunk_tries,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_riff_size,
  output logic [31:0] out_riff_form,
  output logic [31:0] out_fmt_size,
  output logic [15:0] out_audio_format,
  output logic [15:0] out_channel_count,
  output logic [31:0] out_sample_rate,
  output logic [31:0] out_byte_rate,
  output logic [15:0] out_block_align,
  output logic [15:0] out_sample_bits,
  output logic [31:0] out_data_size
);

  logic    in_fire, res_valid, not_full;
  result_t res, out_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = not_full;
  assign in_fire   = in_valid && not_full;

  wrhp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_tries  (cfg_max_chunk_tries),
    .in_fire    (in_fire),
    .data_byte  (in_data_byte),
    .file_start (in_file_start),
    .res_valid  (res_valid),
    .res        (res)
  );

  wrhp_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_valid),
    .wr_data  (res),
    .not_full (not_full),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (out_res)
  );

  assign out_status        = out_res.status;
  assign out_riff_size     = out_res.riff_size;
  assign out_riff_form     = out_res.riff_form;
  assign out_fmt_size      = out_res.fmt_size;
  assign out_audio_format  = out_res.audio_format;
  assign out_channel_count = out_res.channel_count;
  assign out_sample_rate   = out_res.sample_rate;
  assign out_byte_rate     = out_res.byte_rate;
  assign out_block_align   = out_res.block_align;
  assign out_sample_bits   = out_res.sample_bits;
  assign out_data_size     = out_res.data_size;

endmodule

### rtl/core/wrhp_parser.sv
module wrhp_parser
  import wrhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_tries,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       file_start,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  tries_r, tries_nxt;
  logic [7:0]  max_tries_r;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] riff_size_r, riff_size_nxt;
  logic [31:0] riff_form_r, riff_form_nxt;
  logic [31:0] fmt_size_r, fmt_size_nxt;
  logic [7:0]  body_r [16];
  logic        body_we;

  phase_t      ph;
  logic [3:0]  idx;
  logic [7:0]  tries_cur, tries_inc;
  logic [31:0] tag_new, size_new, fmt_rest;
  logic        tries_out, hdr_last, tag_is_fmt, tag_is_data, fmt_short, riff_bad;

  // file start restarts the parse on the flagged byte
  assign ph          = file_start ? PH_RIFF : phase_r;
  assign idx         = file_start ? 4'd0 : byte_index_r;
  assign tries_cur   = file_start ? 8'd0 : tries_r;
  assign tries_inc   = tries_cur + 8'd1;
  assign tries_out   = (tries_inc >= max_tries_r);
  assign tag_new     = {data_byte, tag_r[31:8]};
  assign size_new    = {data_byte, size_r[31:8]};
  assign hdr_last    = (idx == IDX_SIZE_LAST);
  assign tag_is_fmt  = (tag_r == TAG_FMT);
  assign tag_is_data = (tag_r == TAG_DATA);
  assign fmt_short   = (size_new < FMT_MIN);
  assign riff_bad    = (idx == IDX_TAG_LAST) && (tag_new != TAG_RIFF);
  assign fmt_rest    = fmt_size_r - FMT_MIN;

  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      unique case (ph)
        PH_RIFF: begin
          if (riff_bad) phase_nxt = PH_IDLE;
          else if (idx == IDX_FORM_LAST) phase_nxt = PH_FMT_HDR;
          else phase_nxt = PH_RIFF;
        end
        PH_FMT_HDR: begin
          if (!hdr_last) phase_nxt = PH_FMT_HDR;
          else if (tag_is_fmt) phase_nxt = fmt_short ? PH_IDLE : PH_FMT_BODY;
          else if (tries_out) phase_nxt = PH_IDLE;
          else phase_nxt = (size_new == 32'd0) ? PH_FMT_HDR : PH_FMT_SKIP;
        end
        PH_DATA_HDR: begin
          if (!hdr_last) phase_nxt = PH_DATA_HDR;
          else if (tag_is_data || tries_out) phase_nxt = PH_IDLE;
          else phase_nxt = (size_new == 32'd0) ? PH_DATA_HDR : PH_DATA_SKIP;
        end
        PH_FMT_BODY: begin
          if (idx == IDX_BODY_LAST) phase_nxt = (fmt_rest == 32'd0) ? PH_DATA_HDR : PH_DATA_SKIP;
          else phase_nxt = PH_FMT_BODY;
        end
        PH_FMT_SKIP:  phase_nxt = (skip_r == 32'd1) ? PH_FMT_HDR : PH_FMT_SKIP;
        PH_DATA_SKIP: phase_nxt = (skip_r == 32'd1) ? PH_DATA_HDR : PH_DATA_SKIP;
        default:      phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    byte_index_nxt = byte_index_r;
    tries_nxt      = tries_r;
    skip_nxt       = skip_r;
    tag_nxt        = tag_r;
    size_nxt       = size_r;
    riff_size_nxt  = riff_size_r;
    riff_form_nxt  = riff_form_r;
    fmt_size_nxt   = fmt_size_r;
    body_we        = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    if (in_fire) begin
      byte_index_nxt = idx;
      tries_nxt      = tries_cur;
      unique case (ph)
        PH_RIFF: begin
          if (idx <= IDX_TAG_LAST) tag_nxt = tag_new;
          else size_nxt = size_new;
          if (idx == IDX_SIZE_LAST) riff_size_nxt = size_new;
          if (idx == IDX_FORM_LAST) begin
            riff_form_nxt  = size_new;
            tries_nxt      = 8'd0;
            byte_index_nxt = 4'd0;
          end else begin
            byte_index_nxt = idx + 4'd1;
          end
          if (riff_bad) begin
            res_valid  = 1'b1;
            res.status = ST_NOT_RIFF;
          end
        end
        PH_FMT_HDR, PH_DATA_HDR: begin
          if (idx <= IDX_TAG_LAST) tag_nxt = tag_new;
          else size_nxt = size_new;
          if (!hdr_last) begin
            byte_index_nxt = idx + 4'd1;
          end else begin
            byte_index_nxt = 4'd0;
            tries_nxt      = tries_inc;
            skip_nxt       = size_new;
            if (ph == PH_FMT_HDR) begin
              if (tag_is_fmt) begin
                fmt_size_nxt = size_new;
                if (fmt_short) begin
                  res_valid  = 1'b1;
                  res.status = ST_FMT_SHORT;
                end
              end else if (tries_out) begin
                res_valid  = 1'b1;
                res.status = ST_NO_FMT;
              end
            end else begin
              if (tag_is_data) begin
                res_valid         = 1'b1;
                res.status        = ST_OK;
                res.riff_size     = riff_size_r;
                res.riff_form     = riff_form_r;
                res.fmt_size      = fmt_size_r;
                res.audio_format  = {body_r[1], body_r[0]};
                res.channel_count = {body_r[3], body_r[2]};
                res.sample_rate   = {body_r[7], body_r[6], body_r[5], body_r[4]};
                res.byte_rate     = {body_r[11], body_r[10], body_r[9], body_r[8]};
                res.block_align   = {body_r[13], body_r[12]};
                res.sample_bits   = {body_r[15], body_r[14]};
                res.data_size     = size_new;
              end else if (tries_out) begin
                res_valid  = 1'b1;
                res.status = ST_NO_DATA;
              end
            end
          end
        end
        PH_FMT_BODY: begin
          body_we        = 1'b1;
          byte_index_nxt = idx + 4'd1;
          if (idx == IDX_BODY_LAST) begin
            tries_nxt = 8'd0;
            skip_nxt  = fmt_rest;
          end
        end
        PH_FMT_SKIP, PH_DATA_SKIP: begin
          skip_nxt = skip_r - 32'd1;
          if (skip_r == 32'd1) byte_index_nxt = 4'd0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      byte_index_r <= '0;
      tries_r      <= '0;
      max_tries_r  <= TRIES_RESET;
    end else begin
      phase_r      <= phase_nxt;
      byte_index_r <= byte_index_nxt;
      tries_r      <= tries_nxt;
      if (cfg_we) max_tries_r <= cfg_tries;
    end
  end

  always_ff @(posedge clk) begin
    skip_r      <= skip_nxt;
    tag_r       <= tag_nxt;
    size_r      <= size_nxt;
    riff_size_r <= riff_size_nxt;
    riff_form_r <= riff_form_nxt;
    fmt_size_r  <= fmt_size_nxt;
    if (body_we) body_r[idx] <= data_byte;
  end

endmodule

### rtl/core/wrhp_out_fifo.sv
module wrhp_out_fifo
  import wrhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr_en,
  input  result_t wr_data,
  output logic    not_full,
  output logic    rd_valid,
  input  logic    rd_ready,
  output result_t rd_data
);

  result_t    mem_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, rd_ptr_r;
  logic       rd_en;

  assign not_full = ~count_r[1];
  assign rd_valid = (count_r != 2'd0);
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) count_nxt = count_r + 2'd1;
    else if (!wr_en && rd_en) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (wr_en) wr_ptr_r <= ~wr_ptr_r;
      if (rd_en) rd_ptr_r <= ~rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule
